// ===== design/prime_sieve_counter_core_assert.svh =====
// Assertion macros for the sieve core.
// Each macro takes a label, an antecedent and a consequent.
// The clock and the reset are taken from the enclosing module.
`ifndef PRIME_SIEVE_COUNTER_CORE_ASSERT_SVH
`define PRIME_SIEVE_COUNTER_CORE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define PSC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("sieve core check failed");

// The consequent holds in the cycle after the antecedent.
`define PSC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("sieve core check failed");

`endif

// ===== design/psc_pkg.sv =====
`default_nettype none

package psc_pkg;

	// Size of the flag store, one bit per number
	localparam int MAX_LIMIT = 65536;
	localparam int ADDR_W    = $clog2(MAX_LIMIT);

	// Field widths
	localparam int LIMIT_W = 17;
	localparam int COUNT_W = 13;
	localparam int PRIME_W = 16;

	// Sieve base runs up to the square root of the store size
	localparam int BASE_W = ADDR_W / 2 + 1;

endpackage

`default_nettype wire

// ===== design/psc_if.sv =====
`default_nettype none

// Request channel: one limit per transaction
interface psc_req_if
	import psc_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [LIMIT_W-1:0] limit;

	modport source (output valid, output limit, input ready);
	modport sink (input valid, input limit, output ready);
endinterface

// Response channel: prime count and largest prime per transaction
interface psc_rsp_if
	import psc_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] prime_count;
	logic [PRIME_W-1:0] largest_prime;

	modport source (output valid, output prime_count, output largest_prime, input ready);
	modport sink (input valid, input prime_count, input largest_prime, output ready);
endinterface

`default_nettype wire

// ===== design/psc_ram.sv =====
`default_nettype none

module psc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== design/prime_sieve_counter_core.sv =====
// Sieve of Eratosthenes prime counter. Each request transaction carries a
// limit N (saturated to 65536); the single response transaction gives the
// number of primes below N and the largest of them, both 0 when N is 2 or
// less. One request is worked at a time on a 65536 x 1 flag memory with one
// write and one registered read port; the request channel is not ready
// until the result has moved to the output register. The memory needs no
// clearing pass after reset. For N of 2 or more a request runs, from its
// accepting edge to the response, a fill pass, a check of each sieve base
// whose square is below N, a strike of each multiple of each prime base,
// a scan and a final step, paced by the one memory access per cycle and
// one shared adder and comparator, plus any wait for a free output register.
`default_nettype none
`include "prime_sieve_counter_core_assert.svh"

module prime_sieve_counter_core
	import psc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	psc_req_if.sink   req,
	psc_rsp_if.source rsp
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_INIT   = 3'd1;
	localparam logic [2:0] S_BASE   = 3'd2;
	localparam logic [2:0] S_BCHK   = 3'd3;
	localparam logic [2:0] S_STRIKE = 3'd4;
	localparam logic [2:0] S_SCAN   = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	localparam logic [LIMIT_W-1:0] LIMIT_MAX = LIMIT_W'(MAX_LIMIT);
	localparam logic [LIMIT_W-1:0] FIRST     = LIMIT_W'(2);

	logic [2:0]         state_q;
	logic [LIMIT_W-1:0] n_q;
	logic [LIMIT_W-1:0] ptr_q;
	logic [LIMIT_W-1:0] sq_q;
	logic [BASE_W-1:0]  base_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [PRIME_W-1:0] last_q;
	logic               rd_pend_s1;
	logic [ADDR_W-1:0]  rd_addr_s1;
	logic               rsp_valid_q;
	logic [COUNT_W-1:0] rsp_count_q;
	logic [PRIME_W-1:0] rsp_prime_q;

	logic               adv;
	logic [LIMIT_W-1:0] add_a;
	logic [LIMIT_W-1:0] add_b;
	logic [LIMIT_W-1:0] sum;
	logic [LIMIT_W-1:0] cmp_lhs;
	logic               lt;
	logic               ram_we;
	logic               ram_wdata;
	logic [ADDR_W-1:0]  ram_raddr;
	logic               ram_rdata;
	logic               out_free;

	// Advance to the next sieve base: skipped base or strike run finished
	assign adv = ((state_q == S_BCHK) && !ram_rdata) || ((state_q == S_STRIKE) && !lt);

	// Shared adder: pointer step, strike step, or next square (i+1)^2 = i^2 + 2i + 1
	always_comb begin
		add_a = adv ? sq_q : ptr_q;
		if (adv) begin
			add_b = LIMIT_W'({base_q, 1'b1});
		end else if (state_q == S_STRIKE) begin
			add_b = LIMIT_W'(base_q);
		end else begin
			add_b = LIMIT_W'(1);
		end
	end
	assign sum = add_a + add_b;

	// Shared comparator against the limit
	assign cmp_lhs = (state_q == S_BASE) ? sq_q : ptr_q;
	assign lt      = cmp_lhs < n_q;

	// Flag memory access
	assign ram_we    = ((state_q == S_INIT) || (state_q == S_STRIKE)) && lt;
	assign ram_wdata = (state_q == S_INIT);
	assign ram_raddr = (state_q == S_BASE) ? ADDR_W'(base_q) : ptr_q[ADDR_W-1:0];

	psc_ram #(
		.WIDTH(1),
		.DEPTH(MAX_LIMIT)
	) u_flags (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ptr_q[ADDR_W-1:0]),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE);

	assign rsp.valid         = rsp_valid_q;
	assign rsp.prime_count   = rsp_count_q;
	assign rsp.largest_prime = rsp_prime_q;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			rd_pend_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					if (!lt) begin
						state_q <= S_BASE;
					end
				end
				S_BASE: begin
					state_q <= lt ? S_BCHK : S_SCAN;
				end
				S_BCHK: begin
					state_q <= ram_rdata ? S_STRIKE : S_BASE;
				end
				S_STRIKE: begin
					if (!lt) begin
						state_q <= S_BASE;
					end
				end
				S_SCAN: begin
					rd_pend_s1 <= lt;
					if (!lt && !rd_pend_s1) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Present a finished result, drop it on its response transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		rd_addr_s1 <= ptr_q[ADDR_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				n_q    <= (req.limit > LIMIT_MAX) ? LIMIT_MAX : req.limit;
				ptr_q  <= FIRST;
				base_q <= BASE_W'(2);
				sq_q   <= LIMIT_W'(4);
				cnt_q  <= '0;
				last_q <= '0;
			end
			S_INIT: begin
				if (lt) begin
					ptr_q <= sum;
				end
			end
			S_BASE: begin
				if (!lt) begin
					ptr_q <= FIRST;
				end
			end
			S_BCHK, S_STRIKE: begin
				if (adv) begin
					base_q <= base_q + BASE_W'(1);
					sq_q   <= sum;
				end else if (state_q == S_BCHK) begin
					ptr_q <= sq_q;
				end else begin
					ptr_q <= sum;
				end
			end
			S_SCAN: begin
				if (lt) begin
					ptr_q <= sum;
				end
				if (rd_pend_s1 && ram_rdata) begin
					cnt_q  <= cnt_q + COUNT_W'(1);
					last_q <= PRIME_W'(rd_addr_s1);
				end
			end
			S_DONE: begin
				if (out_free) begin
					rsp_count_q <= cnt_q;
					rsp_prime_q <= last_q;
				end
			end
			default: begin
				n_q <= n_q;
			end
		endcase
	end

	// Writes stay below the limit
	`PSC_ASSERT_SAME(a_write_in_range, ram_we, ptr_q < n_q)
	// Scan reads are only in flight during the scan
	`PSC_ASSERT_SAME(a_pend_in_scan, rd_pend_s1, state_q == S_SCAN)
	// A surviving flag during the scan becomes the largest prime seen
	`PSC_ASSERT_NEXT(a_last_tracks, rd_pend_s1 && ram_rdata, last_q == PRIME_W'($past(rd_addr_s1)))
	// Leaving the final state always presents a result
	`PSC_ASSERT_NEXT(a_done_presents, (state_q == S_DONE) && out_free, rsp_valid_q)

endmodule

`default_nettype wire

// ===== tb/sv/psc_sieve_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels, predicts each response from its request limit and
// compares every response transaction against the oldest prediction.
module psc_sieve_checker
	import psc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	psc_req_if       req,
	psc_rsp_if       rsp,
	output int       mismatches,
	output int       pending,
	output int       requests,
	output int       checked
);

	localparam int REPORT_LIMIT = 10;

	typedef struct {
		logic [LIMIT_W-1:0] limit;
		logic [COUNT_W-1:0] prime_count;
		logic [PRIME_W-1:0] largest_prime;
	} sieve_answer_t;

	// Predictions in request order
	sieve_answer_t answer_q [$];

	// Private copy of the block state
	bit                 flag_store [MAX_LIMIT];
	logic [COUNT_W-1:0] tally_reg;
	logic [PRIME_W-1:0] last_prime_reg;

	int fail_total;

	// Run the sieve on the private flag store and return the expected response
	function automatic sieve_answer_t sieve_below(input logic [LIMIT_W-1:0] lim);
		int            n;
		int            base;
		int            mult;
		int            tally;
		int            top;
		sieve_answer_t ans;
		n     = (lim > MAX_LIMIT) ? MAX_LIMIT : int'(lim);
		tally = 0;
		top   = 0;
		// mark every candidate prime
		for (base = 2; base < n; base++)
			flag_store[base] = 1'b1;
		// strike multiples of each surviving base from its square upward
		for (base = 2; base * base < n; base++) begin
			if (flag_store[base]) begin
				for (mult = base * base; mult < n; mult += base)
					flag_store[mult] = 1'b0;
			end
		end
		// count the survivors and keep the last one
		for (base = 2; base < n; base++) begin
			if (flag_store[base]) begin
				tally++;
				top = base;
			end
		end
		tally_reg         = tally[COUNT_W-1:0];
		last_prime_reg    = top[PRIME_W-1:0];
		ans.limit         = lim;
		ans.prime_count   = tally_reg;
		ans.largest_prime = last_prime_reg;
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		sieve_answer_t want;
		if (!arst_n) begin
			answer_q.delete();
			tally_reg      = '0;
			last_prime_reg = '0;
			fail_total     = 0;
			mismatches     <= 0;
			pending        <= 0;
			requests       <= 0;
			checked        <= 0;
		end else begin
			// retire the oldest prediction on each response transaction
			if (rsp.valid && rsp.ready) begin
				if (answer_q.size() == 0) begin
					if (fail_total < REPORT_LIMIT)
						$display("%0t: unexpected response count=%0d largest=%0d",
							$time, rsp.prime_count, rsp.largest_prime);
					fail_total++;
				end else begin
					want = answer_q.pop_front();
					checked <= checked + 1;
					if (rsp.prime_count !== want.prime_count ||
						rsp.largest_prime !== want.largest_prime) begin
						if (fail_total < REPORT_LIMIT) begin
							$write("%0t: limit %0d: expected count=%0d largest=%0d,",
								$time, want.limit, want.prime_count, want.largest_prime);
							$display(" got count=%0d largest=%0d",
								rsp.prime_count, rsp.largest_prime);
						end
						fail_total++;
					end
				end
			end
			// predict each request transaction
			if (req.valid && req.ready) begin
				answer_q = {answer_q, sieve_below(req.limit)};
				requests <= requests + 1;
			end
			pending    <= answer_q.size();
			mismatches <= fail_total;
		end
	end

endmodule

// ===== tb/sv/tb_prime_sieve_counter_core.sv =====
`timescale 1ns / 1ps

module tb_prime_sieve_counter_core;
	import psc_pkg::*;

	localparam int HOLD_CYCLES  = 5000;
	localparam int STALL_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 64;
	localparam int PHASE_ITEMS  = 26;
	localparam int CORNER_COUNT = 22;

	// Edge limits: empty range, the first primes, squares where striking
	// starts, the top of the range and a saturating all-ones limit
	localparam int CORNER_LIMITS [CORNER_COUNT] = '{
		0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13,
		25, 49, 50, 121, 122, 1000, 65535, 131071
	};

	logic clk = 1'b0;
	logic arst_n;

	int send_idle_pct;
	int recv_idle_pct;
	bit hold_request;
	int held;
	int quiet_cycles;
	int mismatches;
	int pending;
	int requests;
	int checked;

	psc_req_if req_ch ();
	psc_rsp_if rsp_ch ();

	prime_sieve_counter_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	psc_sieve_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.mismatches (mismatches),
		.pending    (pending),
		.requests   (requests),
		.checked    (checked)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Mostly small limits, some mid sizes, a few larger stores
	function automatic logic [LIMIT_W-1:0] pick_limit();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 6)
			return LIMIT_W'($urandom_range(3));
		else if (roll < 66)
			return LIMIT_W'($urandom_range(256, 4));
		else if (roll < 94)
			return LIMIT_W'($urandom_range(2048, 257));
		else
			return LIMIT_W'($urandom_range(16384, 2049));
	endfunction

	// Offer one limit after random idle cycles; return at its accepting edge
	task automatic send_limit(input logic [LIMIT_W-1:0] lim);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.limit <= lim;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// Drive requests and give the verdict
	initial begin
		arst_n        = 1'b0;
		req_ch.valid  <= 1'b0;
		req_ch.limit  <= '0;
		send_idle_pct = 13;
		recv_idle_pct = 71;
		hold_request  = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (CORNER_LIMITS[k])
			send_limit(LIMIT_W'(CORNER_LIMITS[k]));
		repeat (PHASE_ITEMS) send_limit(pick_limit());

		send_idle_pct = 71;
		recv_idle_pct = 13;
		repeat (PHASE_ITEMS) send_limit(pick_limit());

		// no idling; hold off responses so the block backs up its input
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request  = 1'b1;
		repeat (PHASE_ITEMS) send_limit(pick_limit());
		req_ch.valid <= 1'b0;

		do
			@(posedge clk);
		while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d limits (edge cases, small and mid sizes, full and saturated store),",
			requests);
		$display("checked %0d responses under mixed idling and a %0d-cycle response hold-off.",
			checked, HOLD_CYCLES);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Drive response ready, with one long hold-off when asked
	initial begin
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				rsp_ch.ready <= 1'b0;
				for (held = 0; held < HOLD_CYCLES; held++)
					@(posedge clk);
			end
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// End the run if no transaction moves for too long
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (arst_n) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end else begin
			quiet_cycles <= 0;
		end
	end

endmodule
